>>> rtl/core/shrp_pkg.sv
// Package for the seeded roll-and-pick hash: word types, mix constants, helpers.
`default_nettype none
package shrp_pkg;

    localparam logic [63:0] MIX_A = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_B = 64'hD1B54A32D192ED03;
    localparam logic [63:0] FIN_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] FIN_B = 64'h94D049BB133111EB;

    // 2^16k mod 100 for the 16-bit chunks of a 64-bit value
    localparam logic [6:0] POW16_MOD = 7'd36;
    localparam logic [6:0] POW32_MOD = 7'd96;
    localparam logic [6:0] POW48_MOD = 7'd56;
    localparam logic [6:0] PCT_MOD   = 7'd100;
    // ceil(2^32 / 100), exact quotient for values below 2^24
    localparam logic [25:0] PCT_RECIP = 26'd42949673;

    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 8;

    typedef struct packed {
        logic        command;
        logic [63:0] seed;
        logic [31:0] roll_index;
        logic [63:0] roll_salt;
        logic [31:0] pick_index;
        logic [63:0] pick_salt;
        logic        event_present;
        logic [15:0] eligible_count;
    } in_word_t;

    typedef struct packed {
        logic [63:0] roll_hash;
        logic        fires;
        logic        slot_valid;
        logic [15:0] slot;
    } out_word_t;

    // low 64 bits of the low-half product
    function automatic logic [63:0] mul_lo(input logic [63:0] a, input logic [63:0] c);
        logic [63:0] p;
        p = a[31:0] * c[31:0];
        return p;
    endfunction

    // low 32 bits of the two cross products, which land at bit 32
    function automatic logic [31:0] mul_cross(input logic [63:0] a, input logic [63:0] c);
        logic [63:0] p0;
        logic [63:0] p1;
        p0 = a[63:32] * c[31:0];
        p1 = a[31:0] * c[63:32];
        return p0[31:0] + p1[31:0];
    endfunction

    // eight restoring remainder steps
    function automatic logic [15:0] rem_step8(input logic [15:0] rem, input logic [7:0] bits,
                                              input logic [15:0] cnt);
        logic [16:0] t;
        logic [15:0] r;
        r = rem;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, cnt})
            begin
                t = t - {1'b0, cnt};
            end
            r = t[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/seeded_hash_roll_and_pick_top.sv
// Top level of the seeded roll-and-pick hash: a 15-stage pipeline.
//
// Input channel in_valid/in_stall/in_data carries one word per item: a seed, a roll
// pair and a pick pair (index, salt), the event flag and the eligible count.
// Output channel out_valid/out_stall/out_data returns one word per item: the roll
// hash, the fires flag and the picked slot with its valid bit.
// cfg_we/cfg_wdata write the chance percentage; write it only while the pipe is empty.
// out_valid rises when the item reaches the last stage, and the result word can be taken
// from then on. One item is accepted per cycle while the pipe is not frozen by out_stall.
// Stages 1-7 compute both keyed hashes, each 64-bit multiply taking a partial-product
// stage and a sum stage; stages 8-10 reduce the roll hash modulo 100; stages 8-15
// take the pick hash modulo the count, eight quotient bits per stage.
// The last stage is the output register. While out_stall holds a waiting word, the
// whole pipe freezes and in_stall rises; nothing is lost or repeated.
// Reset clears all valid bits and the chance percentage to 0.
`default_nettype none
module seeded_hash_roll_and_pick_top
    import shrp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [6:0] cfg_wdata
);

    localparam int NSTG = 15;

    typedef struct packed {
        logic        command;
        logic        event_present;
        logic [15:0] eligible_count;
        logic [63:0] seed;
        logic [63:0] roll_hash;
        logic        fires;
    } meta_t;

    logic              en;
    logic [6:0]        chance_reg;
    logic [NSTG:1]     v_reg;
    meta_t             meta_reg [1:NSTG];

    // hash lanes: 0 = roll, 1 = pick
    logic [63:0] ia_reg  [2];
    logic [63:0] sa_reg  [2];
    logic [63:0] lla_reg [2];
    logic [31:0] cra_reg [2];
    logic [63:0] llb_reg [2];
    logic [31:0] crb_reg [2];
    logic [63:0] x3_reg  [2];
    logic [63:0] ll4_reg [2];
    logic [31:0] cr4_reg [2];
    logic [63:0] x5_reg  [2];
    logic [63:0] ll6_reg [2];
    logic [31:0] cr6_reg [2];
    logic [63:0] h7_reg  [2];

    // roll modulo 100
    logic [23:0] sum8_reg;
    logic [23:0] v9_reg;
    logic [17:0] q9_reg;

    // pick remainder stages 8..15
    logic [63:0] pk_reg  [DIV_STAGES];
    logic [15:0] rem_reg [DIV_STAGES];

    logic [49:0] q_full;
    logic [23:0] qx100;
    logic [23:0] r_full;
    logic [6:0]  r_mod;
    logic [63:0] prod3a;
    logic [63:0] prod3b;
    logic [63:0] x3_next [2];
    meta_t       meta8_next;
    meta_t       meta10_next;

    // advance the whole pipe unless the output word is held
    assign en        = !(v_reg[NSTG] && out_stall);
    assign in_stall  = !en;
    assign out_valid = v_reg[NSTG];

    // hold chance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chance_reg <= '0;
        end
        else if (cfg_we)
        begin
            chance_reg <= cfg_wdata;
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTG-1:1], in_valid};
        end
    end

    // mix sums and modulo-100 arithmetic
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            prod3a     = lla_reg[l] + {cra_reg[l], 32'd0};
            prod3b     = llb_reg[l] + {crb_reg[l], 32'd0};
            x3_next[l] = meta_reg[2].seed ^ prod3a ^ prod3b;
        end
        q_full = {26'd0, sum8_reg} * {24'd0, PCT_RECIP};
        qx100  = 24'(q9_reg) * 24'(PCT_MOD);
        r_full = v9_reg - qx100;
        r_mod  = r_full[6:0];

        // load roll hash at stage 8, fires flag at stage 10
        meta8_next           = meta_reg[7];
        meta8_next.roll_hash = h7_reg[0];
        meta10_next          = meta_reg[9];
        meta10_next.fires    = !meta_reg[9].command && meta_reg[9].event_present
                               && (r_mod < chance_reg);
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: capture item, add one to index and salt
            meta_reg[1].command        <= in_data.command;
            meta_reg[1].event_present  <= in_data.event_present;
            meta_reg[1].eligible_count <= in_data.eligible_count;
            meta_reg[1].seed           <= in_data.seed;
            meta_reg[1].roll_hash      <= '0;
            meta_reg[1].fires          <= 1'b0;
            ia_reg[0] <= {{32{in_data.roll_index[31]}}, in_data.roll_index} + 64'd1;
            ia_reg[1] <= {{32{in_data.pick_index[31]}}, in_data.pick_index} + 64'd1;
            sa_reg[0] <= in_data.roll_salt + 64'd1;
            sa_reg[1] <= in_data.pick_salt + 64'd1;

            for (int s = 2; s <= NSTG; s++)
            begin
                if (s != 8 && s != 10)
                begin
                    meta_reg[s] <= meta_reg[s-1];
                end
            end
            meta_reg[8]  <= meta8_next;
            meta_reg[10] <= meta10_next;

            for (int l = 0; l < 2; l++)
            begin
                // stage 2: partial products of the mix
                lla_reg[l] <= mul_lo(ia_reg[l], MIX_A);
                cra_reg[l] <= mul_cross(ia_reg[l], MIX_A);
                llb_reg[l] <= mul_lo(sa_reg[l], MIX_B);
                crb_reg[l] <= mul_cross(sa_reg[l], MIX_B);
                // stage 3: combine with seed, first xorshift
                x3_reg[l]  <= x3_next[l] ^ (x3_next[l] >> 30);
                // stage 4: partial products by first finalizer constant
                ll4_reg[l] <= mul_lo(x3_reg[l], FIN_A);
                cr4_reg[l] <= mul_cross(x3_reg[l], FIN_A);
                // stage 6: partial products by second finalizer constant
                ll6_reg[l] <= mul_lo(x5_reg[l], FIN_B);
                cr6_reg[l] <= mul_cross(x5_reg[l], FIN_B);
            end

            // stage 5 and stage 7: sum products, xorshift
            for (int l = 0; l < 2; l++)
            begin
                x5_reg[l] <= (ll4_reg[l] + {cr4_reg[l], 32'd0})
                           ^ ((ll4_reg[l] + {cr4_reg[l], 32'd0}) >> 27);
                h7_reg[l] <= (ll6_reg[l] + {cr6_reg[l], 32'd0})
                           ^ ((ll6_reg[l] + {cr6_reg[l], 32'd0}) >> 31);
            end

            // stage 8: fold roll hash chunks modulo 100, start pick remainder
            sum8_reg <= 24'(h7_reg[0][15:0])
                      + 24'(h7_reg[0][31:16]) * 24'(POW16_MOD)
                      + 24'(h7_reg[0][47:32]) * 24'(POW32_MOD)
                      + 24'(h7_reg[0][63:48]) * 24'(POW48_MOD);
            pk_reg[0]  <= h7_reg[1];
            rem_reg[0] <= rem_step8(16'd0, h7_reg[1][63:56], meta_reg[7].eligible_count);

            // stage 9: quotient by 100
            v9_reg <= sum8_reg;
            q9_reg <= q_full[49:32];

            // stages 9..15: remaining quotient bits of the pick
            for (int d = 1; d < DIV_STAGES; d++)
            begin
                pk_reg[d]  <= pk_reg[d-1];
                rem_reg[d] <= rem_step8(rem_reg[d-1],
                                        pk_reg[d-1][63-DIV_BITS*d -: DIV_BITS],
                                        meta_reg[7+d].eligible_count);
            end
        end
    end

    // drive output word from the last stage
    always_comb
    begin
        out_data.roll_hash  = meta_reg[NSTG].roll_hash;
        out_data.fires      = meta_reg[NSTG].fires;
        out_data.slot_valid = (meta_reg[NSTG].eligible_count != 16'd0)
                              && (meta_reg[NSTG].command || meta_reg[NSTG].fires);
        out_data.slot       = out_data.slot_valid ? rem_reg[DIV_STAGES-1] : 16'd0;
    end

    // checks
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.slot_valid) |-> (out_data.slot == 16'd0))
        else $error("slot not zero without a valid pick");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.slot_valid)
            |-> (out_data.slot < meta_reg[NSTG].eligible_count))
        else $error("slot beyond eligible count");

    a_fire_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.fires)
            |-> (!meta_reg[NSTG].command && meta_reg[NSTG].event_present))
        else $error("roll fired in pick-only mode or without event");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");

endmodule
`default_nettype wire
